[rtl/core/mexp_pkg.sv]
// Package for the modular exponentiation core: widths, reset values and sequencer states.
`default_nettype none

package mexp_pkg;

  // Field widths of the ports and the configuration register
  localparam int unsigned FIELD_W           = 32;
  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  // Modulus after reset
  localparam logic [FIELD_W-1:0] MODULUS_RST = 32'd11;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/modular_exponentiation_core.sv]
// Modular exponentiation core: base^exponent mod modulus by square-and-multiply.
`default_nettype none

// The core takes one beat of {base_value, exponent} and returns one beat holding
// base_value^exponent mod modulus, always fully reduced. The modulus is a single
// register written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the core is idle, which the core itself does not enforce. It resets to 11.
// A modulus of 0 gives a remainder of 0, a modulus of 1 gives 0, and, for a
// modulus above 1, an exponent of 0 gives 1. Operands and the modulus are taken
// at their low OPERAND_WIDTH bits. All arithmetic runs through one shared modular
// adder: a modular multiplication walks the multiplier bits from the top,
// doubling the partial product for each bit and adding the multiplicand for each
// set bit. An item first reduces the base (one such multiplication), then for
// every one of the W exponent bits (W = OPERAND_WIDTH) performs a squaring and,
// for a set bit, a multiplication by the base. in_stall is high from the accepted
// beat until the core returns to idle. The finished remainder sits in an output
// register, so a new beat is taken as soon as the core returns to idle, even
// while the previous result still waits on out_stall.
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [FIELD_W-1:0] cfg_wr_data,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FIELD_W-1:0] in_base_value,
  input  wire logic [FIELD_W-1:0] in_exponent,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FIELD_W-1:0]      out_remainder
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  // Control state
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] modulus_r;

  // Payload state
  logic [W-1:0]       acc_r, acc_nxt;       // running power
  logic [W-1:0]       base_r, base_nxt;     // reduced base
  logic [W-1:0]       exp_r, exp_nxt;       // exponent, shifted left as bits are used
  logic [CNT_W-1:0]   ecnt_r, ecnt_nxt;     // exponent bits still to go, minus one
  logic [FIELD_W-1:0] out_rem_r, out_rem_nxt;

  // Shared modular multiplier state
  logic [W-1:0]       p_r, p_nxt;           // partial product
  logic [W-1:0]       x_r, x_nxt;           // multiplicand
  logic [W-1:0]       y_r, y_nxt;           // multiplier, shifted left per bit
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               phase_r, phase_nxt;   // 0: double, 1: add multiplicand

  logic [W-1:0] mod_w;
  logic         in_acc;
  logic         out_free;
  logic         busy;
  logic [W:0]   sum;
  logic [W:0]   sum_red;
  logic [W-1:0] red;
  logic         mm_adv;
  logic         mm_last;

  assign mod_w    = W'(modulus_r);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign busy     = (state_r == ST_REDUCE) || (state_r == ST_SQUARE) || (state_r == ST_MULT);

  // Shared modular adder: p + p or p + x, one conditional subtract of the modulus.
  // Both operands are below the modulus, so one subtract is enough.
  assign sum     = {1'b0, p_r} + {1'b0, (phase_r ? x_r : p_r)};
  assign sum_red = (sum >= {1'b0, mod_w}) ? (sum - {1'b0, mod_w}) : sum;
  assign red     = sum_red[W-1:0];

  // Advance to the next multiplier bit after the add, or after the double on a clear bit
  assign mm_adv  = phase_r || !y_r[W-1];
  assign mm_last = busy && mm_adv && (cnt_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (mod_w == '0) ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_last) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_last) begin
          if (exp_r[W-1]) begin
            state_nxt = ST_MULT;
          end else if (ecnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SQUARE;
          end
        end
      end
      ST_MULT: begin
        if (mm_last) begin
          state_nxt = (ecnt_r == '0) ? ST_DONE : ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    ecnt_nxt      = ecnt_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rem_nxt   = out_rem_r;

    // Step the shared multiplier
    if (busy) begin
      p_nxt = red;
      if (mm_adv) begin
        phase_nxt = 1'b0;
        y_nxt     = y_r << 1;
        cnt_nxt   = cnt_r - 1'b1;
      end else begin
        phase_nxt = 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Reduce the base as (1 * base) mod m; with a modulus of one everything is zero
          acc_nxt   = (mod_w == W'(1) || mod_w == '0) ? '0 : W'(1);
          x_nxt     = (mod_w == W'(1)) ? '0 : W'(1);
          y_nxt     = W'(in_base_value);
          exp_nxt   = W'(in_exponent);
          ecnt_nxt  = CNT_LAST;
          p_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          phase_nxt = 1'b0;
        end
      end
      ST_REDUCE: begin
        if (mm_last) begin
          base_nxt  = red;
          x_nxt     = acc_r;
          y_nxt     = acc_r;
          p_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          phase_nxt = 1'b0;
        end
      end
      ST_SQUARE: begin
        if (mm_last) begin
          acc_nxt   = red;
          p_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          phase_nxt = 1'b0;
          if (exp_r[W-1]) begin
            x_nxt = red;
            y_nxt = base_r;
          end else begin
            exp_nxt  = exp_r << 1;
            ecnt_nxt = ecnt_r - 1'b1;
            x_nxt    = red;
            y_nxt    = red;
          end
        end
      end
      ST_MULT: begin
        if (mm_last) begin
          acc_nxt   = red;
          exp_nxt   = exp_r << 1;
          ecnt_nxt  = ecnt_r - 1'b1;
          x_nxt     = red;
          y_nxt     = red;
          p_nxt     = '0;
          cnt_nxt   = CNT_LAST;
          phase_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rem_nxt   = FIELD_W'(acc_r);
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    exp_r     <= exp_nxt;
    ecnt_r    <= ecnt_nxt;
    p_r       <= p_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    cnt_r     <= cnt_nxt;
    phase_r   <= phase_nxt;
    out_rem_r <= out_rem_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_remainder = out_rem_r;

  // The partial product stays reduced throughout a multiplication
  a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (p_r < mod_w))
    else $error("partial product not below modulus");

  // The multiplicand stays reduced, otherwise one subtract would not suffice
  a_multiplicand_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (x_r < mod_w))
    else $error("multiplicand not below modulus");

  // The running power stays reduced while squaring and multiplying
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SQUARE) || (state_r == ST_MULT)) |-> (acc_r < mod_w))
    else $error("running power not below modulus");

  // A finished item reaches the output register and frees the input side together
  a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result hand-off lost");

endmodule

`default_nettype wire
